// ----- hw/rtl/tlp_pkg.sv -----
package tlp_pkg;

  // Field widths fixed by the interface.
  localparam int CHAR_BITS = 8;
  localparam int TEAM_BITS = 16;
  localparam int OUT_PRESSURE_BITS = 32;

  // Number ranges of the three numeric fields.
  localparam int PRESSURE_BITS = 32;
  localparam int TEAM_ID_BITS = 16;
  localparam int TIME_NUM_BITS = 8;

  // The accumulator holds the widest of the numeric fields.
  localparam int ACC_BITS_A = (PRESSURE_BITS > TEAM_ID_BITS) ? PRESSURE_BITS : TEAM_ID_BITS;
  localparam int ACC_BITS = (ACC_BITS_A > TIME_NUM_BITS) ? ACC_BITS_A : TIME_NUM_BITS;
  // Ten times the accumulator plus a digit needs four more bits.
  localparam int PROD_BITS = ACC_BITS + 4;

  // Largest legal value of each numeric field, at product width.
  localparam logic [PROD_BITS-1:0] LIM_TEAM =
    {{(PROD_BITS-TEAM_ID_BITS){1'b0}}, {TEAM_ID_BITS{1'b1}}};
  localparam logic [PROD_BITS-1:0] LIM_TIME =
    {{(PROD_BITS-TIME_NUM_BITS){1'b0}}, {TIME_NUM_BITS{1'b1}}};
  localparam logic [PROD_BITS-1:0] LIM_PRESSURE =
    {{(PROD_BITS-PRESSURE_BITS){1'b0}}, {PRESSURE_BITS{1'b1}}};

  // Range checks of the time value.
  localparam logic [ACC_BITS-1:0] HOURS_LIMIT = ACC_BITS'(24);
  localparam logic [ACC_BITS-1:0] MINSEC_LIMIT = ACC_BITS'(60);

  // Keyword buffer: eight bytes, length saturates one past the buffer.
  localparam int KW_BYTES = 8;
  localparam int KW_BITS = KW_BYTES * CHAR_BITS;
  localparam logic [3:0] KW_LEN_SAT = 4'(KW_BYTES + 1);

  // Keywords, first character in the low byte.
  localparam logic [KW_BITS-1:0] KW_CMD      = 64'h0000_0000_0044_4D43;
  localparam logic [KW_BITS-1:0] KW_CX       = 64'h0000_0000_0000_5843;
  localparam logic [KW_BITS-1:0] KW_ST       = 64'h0000_0000_0000_5453;
  localparam logic [KW_BITS-1:0] KW_SIM      = 64'h0000_0000_004D_4953;
  localparam logic [KW_BITS-1:0] KW_SIMP     = 64'h0000_0000_504D_4953;
  localparam logic [KW_BITS-1:0] KW_ON       = 64'h0000_0000_0000_4E4F;
  localparam logic [KW_BITS-1:0] KW_OFF      = 64'h0000_0000_0046_464F;
  localparam logic [KW_BITS-1:0] KW_ENABLE   = 64'h0000_454C_4241_4E45;
  localparam logic [KW_BITS-1:0] KW_DISABLE  = 64'h0045_4C42_4153_4944;
  localparam logic [KW_BITS-1:0] KW_ACTIVATE = 64'h4554_4156_4954_4341;

  localparam logic [3:0] KW_CMD_LEN      = 4'd3;
  localparam logic [3:0] KW_CX_LEN       = 4'd2;
  localparam logic [3:0] KW_ST_LEN       = 4'd2;
  localparam logic [3:0] KW_SIM_LEN      = 4'd3;
  localparam logic [3:0] KW_SIMP_LEN     = 4'd4;
  localparam logic [3:0] KW_ON_LEN       = 4'd2;
  localparam logic [3:0] KW_OFF_LEN      = 4'd3;
  localparam logic [3:0] KW_ENABLE_LEN   = 4'd6;
  localparam logic [3:0] KW_DISABLE_LEN  = 4'd7;
  localparam logic [3:0] KW_ACTIVATE_LEN = 4'd8;

  // Characters the front end classifies.
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CH_COLON = 8'h3A;

  // Command kinds (format keyword of the third field).
  localparam logic [1:0] FMT_CX   = 2'd0;
  localparam logic [1:0] FMT_ST   = 2'd1;
  localparam logic [1:0] FMT_SIM  = 2'd2;
  localparam logic [1:0] FMT_SIMP = 2'd3;

  // Simulation modes.
  localparam logic [1:0] SIM_ENABLE   = 2'd0;
  localparam logic [1:0] SIM_DISABLE  = 2'd1;
  localparam logic [1:0] SIM_ACTIVATE = 2'd2;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic [CHAR_BITS-1:0] code;
    logic                 last;
    logic                 is_digit;
    logic [3:0]           digit;
    logic                 is_comma;
    logic                 is_colon;
  } tlp_item_t;

endpackage

// ----- hw/rtl/telecommand_line_parser.sv -----
// The last character of a line passes through the queue and then the output register before
// the earliest transfer of its verdict.
// Throughput: one character per cycle while in_stall is low; the back end parses one a cycle.
// A line ending waits only while an earlier verdict still sits in the output register.
// A two-entry queue separates the input from the parser, so in_stall depends on it alone.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid, clears the parse state
// and sets the team number to zero.
module telecommand_line_parser (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tlp_pkg::TEAM_BITS-1:0]         cfg_team_number,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [tlp_pkg::CHAR_BITS-1:0]         in_char_code,
  input  logic                                  in_last_char,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_accepted,
  output logic [1:0]                            out_command_kind,
  output logic                                  out_telemetry_on,
  output logic [4:0]                            out_hours,
  output logic [5:0]                            out_minutes,
  output logic [5:0]                            out_seconds,
  output logic [1:0]                            out_sim_mode,
  output logic [tlp_pkg::OUT_PRESSURE_BITS-1:0] out_pressure
);

  logic               q_valid;
  logic               q_pop;
  tlp_pkg::tlp_item_t q_item;

  // Front end: accepts and classifies characters into the queue.
  tlp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // Back end: parses the line and holds the verdict.
  tlp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_team_number  (cfg_team_number),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_command_kind (out_command_kind),
    .out_telemetry_on (out_telemetry_on),
    .out_hours        (out_hours),
    .out_minutes      (out_minutes),
    .out_seconds      (out_seconds),
    .out_sim_mode     (out_sim_mode),
    .out_pressure     (out_pressure)
  );

endmodule

// ----- hw/rtl/tlp_front.sv -----
module tlp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlp_pkg::CHAR_BITS-1:0] in_char_code,
  input  logic                          in_last_char,
  output logic                          q_valid,
  output tlp_pkg::tlp_item_t            q_item,
  input  logic                          q_pop
);

  tlp_pkg::tlp_item_t                  item_in;
  tlp_pkg::tlp_item_t                  q_r [tlp_pkg::QDEPTH];
  logic [tlp_pkg::QPTR_BITS-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [tlp_pkg::QPTR_BITS-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [tlp_pkg::QCNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic [tlp_pkg::CHAR_BITS-1:0]       digit_full;
  logic                                push;

  // Classify the incoming character once, on its way into the queue.
  always_comb begin
    digit_full        = in_char_code - tlp_pkg::CH_ZERO;
    item_in.code      = in_char_code;
    item_in.last      = in_last_char;
    item_in.is_digit  = (in_char_code >= tlp_pkg::CH_ZERO) &&
                        (in_char_code <= tlp_pkg::CH_NINE);
    item_in.digit     = digit_full[3:0];
    item_in.is_comma  = (in_char_code == tlp_pkg::CH_COMMA);
    item_in.is_colon  = (in_char_code == tlp_pkg::CH_COLON);
  end

  // The queue stalls the input only when every entry is taken.
  assign in_stall = (cnt_r == tlp_pkg::QCNT_BITS'(tlp_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tlp_pkg::QPTR_BITS'(tlp_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == tlp_pkg::QPTR_BITS'(tlp_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, q_pop})
      2'b10: begin
        cnt_nxt = cnt_r + 1'b1;
      end
      2'b01: begin
        cnt_nxt = cnt_r - 1'b1;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue entries carry payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tlp_pkg::QCNT_BITS'(tlp_pkg::QDEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");
  a_push_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_pop) |=> cnt_r == $past(cnt_r))
    else $error("simultaneous push and pop changed the count");
`endif

endmodule

// ----- hw/rtl/tlp_back.sv -----
module tlp_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tlp_pkg::TEAM_BITS-1:0]         cfg_team_number,
  input  logic                                  q_valid,
  input  tlp_pkg::tlp_item_t                    q_item,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_accepted,
  output logic [1:0]                            out_command_kind,
  output logic                                  out_telemetry_on,
  output logic [4:0]                            out_hours,
  output logic [5:0]                            out_minutes,
  output logic [5:0]                            out_seconds,
  output logic [1:0]                            out_sim_mode,
  output logic [tlp_pkg::OUT_PRESSURE_BITS-1:0] out_pressure
);

  // Field positions within the line.
  localparam logic [2:0] FIELD_CMD   = 3'd0;
  localparam logic [2:0] FIELD_TEAM  = 3'd1;
  localparam logic [2:0] FIELD_FMT   = 3'd2;
  localparam logic [2:0] FIELD_VALUE = 3'd3;
  localparam logic [2:0] FIELD_DONE  = 3'd4;

  // Parts of the time value.
  localparam logic [1:0] TP_HOURS   = 2'd0;
  localparam logic [1:0] TP_MINUTES = 2'd1;
  localparam logic [1:0] TP_SECONDS = 2'd2;
  localparam logic [1:0] TP_DONE    = 2'd3;

  typedef struct packed {
    logic [2:0]                     fidx;
    logic [tlp_pkg::KW_BITS-1:0]    kw;
    logic [3:0]                     kwlen;
    logic [tlp_pkg::ACC_BITS-1:0]   acc;
    logic                           seen;
    logic                           stop;
    logic                           ovf;
    logic [1:0]                     fmt;
    logic                           rej;
    logic [1:0]                     tpart;
    logic [4:0]                     hh;
    logic [5:0]                     mm;
  } tlp_parse_t;

  tlp_parse_t                             st_r, st_nxt, s1, s2;
  logic [tlp_pkg::TEAM_BITS-1:0]          team_r;
  logic                                   out_valid_r;
  logic                                   out_accepted_r;
  logic [1:0]                             out_kind_r;
  logic                                   out_tel_r;
  logic [4:0]                             out_hours_r;
  logic [5:0]                             out_minutes_r;
  logic [5:0]                             out_seconds_r;
  logic [1:0]                             out_sim_r;
  logic [tlp_pkg::OUT_PRESSURE_BITS-1:0]  out_pressure_r;
  logic                                   res_accepted;
  logic [1:0]                             res_kind;
  logic                                   res_tel;
  logic [4:0]                             res_hours;
  logic [5:0]                             res_minutes;
  logic [5:0]                             res_seconds;
  logic [1:0]                             res_sim;
  logic [tlp_pkg::OUT_PRESSURE_BITS-1:0]  res_pressure;
  logic                                   out_free;

  // A keyword matches when both its length and its bytes agree.
  function automatic logic kw_is(tlp_parse_t s, logic [tlp_pkg::KW_BITS-1:0] word,
                                 logic [3:0] wlen);
    return (s.kwlen == wlen) && (s.kw == word);
  endfunction

  function automatic logic num_ok(tlp_parse_t s);
    return s.seen && !s.ovf;
  endfunction

  // Append one character to the keyword buffer.
  function automatic tlp_parse_t kw_char(tlp_parse_t s, logic [tlp_pkg::CHAR_BITS-1:0] c);
    tlp_parse_t r;
    r = s;
    for (int i = 0; i < tlp_pkg::KW_BYTES; i++) begin
      if (s.kwlen == 4'(i)) begin
        r.kw[tlp_pkg::CHAR_BITS*i +: tlp_pkg::CHAR_BITS] = c;
      end
    end
    if (s.kwlen != tlp_pkg::KW_LEN_SAT) begin
      r.kwlen = s.kwlen + 4'd1;
    end
    return r;
  endfunction

  // Take one character of a number: leading digits only, overflow rejects.
  function automatic tlp_parse_t num_char(tlp_parse_t s, logic dig, logic [3:0] d,
                                          logic [tlp_pkg::PROD_BITS-1:0] lim);
    tlp_parse_t                     r;
    logic [tlp_pkg::PROD_BITS-1:0]  wide;
    logic [tlp_pkg::PROD_BITS-1:0]  prod;
    r    = s;
    wide = {4'b0, s.acc};
    prod = (wide << 3) + (wide << 1) + {{(tlp_pkg::PROD_BITS-4){1'b0}}, d};
    if (!s.stop) begin
      if (!dig) begin
        r.stop = 1'b1;
      end else begin
        r.seen = 1'b1;
        if (!s.ovf) begin
          if (prod > lim) begin
            r.ovf = 1'b1;
          end else begin
            r.acc = prod[tlp_pkg::ACC_BITS-1:0];
          end
        end
      end
    end
    return r;
  endfunction

  // Close one part of the time value and check its range.
  function automatic tlp_parse_t finish_time_part(tlp_parse_t s);
    tlp_parse_t r;
    r = s;
    if (!num_ok(s)) begin
      r.rej = 1'b1;
    end else if (s.tpart == TP_HOURS) begin
      if (s.acc >= tlp_pkg::HOURS_LIMIT) begin
        r.rej = 1'b1;
      end else begin
        r.hh = s.acc[4:0];
      end
    end else begin
      if (s.acc >= tlp_pkg::MINSEC_LIMIT) begin
        r.rej = 1'b1;
      end else if (s.tpart == TP_MINUTES) begin
        r.mm = s.acc[5:0];
      end
    end
    // The seconds stay in the accumulator for the result.
    if (s.tpart == TP_HOURS || s.tpart == TP_MINUTES) begin
      r.acc  = '0;
      r.seen = 1'b0;
      r.stop = 1'b0;
      r.ovf  = 1'b0;
    end
    r.tpart = s.tpart + 2'd1;
    return r;
  endfunction

  // Close the current field and check it.
  function automatic tlp_parse_t finish_field(tlp_parse_t s,
                                              logic [tlp_pkg::TEAM_BITS-1:0] team);
    tlp_parse_t r;
    r = s;
    unique case (s.fidx)
      FIELD_CMD: begin
        if (!kw_is(s, tlp_pkg::KW_CMD, tlp_pkg::KW_CMD_LEN)) r.rej = 1'b1;
      end
      FIELD_TEAM: begin
        if (!num_ok(s) ||
            s.acc != {{(tlp_pkg::ACC_BITS-tlp_pkg::TEAM_BITS){1'b0}}, team}) begin
          r.rej = 1'b1;
        end
      end
      FIELD_FMT: begin
        priority if (kw_is(s, tlp_pkg::KW_CX, tlp_pkg::KW_CX_LEN)) begin
          r.fmt = tlp_pkg::FMT_CX;
        end else if (kw_is(s, tlp_pkg::KW_ST, tlp_pkg::KW_ST_LEN)) begin
          r.fmt = tlp_pkg::FMT_ST;
        end else if (kw_is(s, tlp_pkg::KW_SIM, tlp_pkg::KW_SIM_LEN)) begin
          r.fmt = tlp_pkg::FMT_SIM;
        end else if (kw_is(s, tlp_pkg::KW_SIMP, tlp_pkg::KW_SIMP_LEN)) begin
          r.fmt = tlp_pkg::FMT_SIMP;
        end else begin
          r.rej = 1'b1;
        end
      end
      default: begin
        unique case (s.fmt)
          tlp_pkg::FMT_CX: begin
            if (!kw_is(s, tlp_pkg::KW_ON, tlp_pkg::KW_ON_LEN) &&
                !kw_is(s, tlp_pkg::KW_OFF, tlp_pkg::KW_OFF_LEN)) r.rej = 1'b1;
          end
          tlp_pkg::FMT_ST: begin
            if (s.tpart != TP_DONE) r = finish_time_part(s);
            if (r.tpart != TP_DONE) r.rej = 1'b1;
          end
          tlp_pkg::FMT_SIM: begin
            if (!kw_is(s, tlp_pkg::KW_ENABLE, tlp_pkg::KW_ENABLE_LEN) &&
                !kw_is(s, tlp_pkg::KW_DISABLE, tlp_pkg::KW_DISABLE_LEN) &&
                !kw_is(s, tlp_pkg::KW_ACTIVATE, tlp_pkg::KW_ACTIVATE_LEN)) begin
              r.rej = 1'b1;
            end
          end
          default: begin
            if (!num_ok(s)) r.rej = 1'b1;
          end
        endcase
      end
    endcase
    // The value field stays in place for the result.
    if (s.fidx != FIELD_VALUE) begin
      r.kw    = '0;
      r.kwlen = '0;
      r.acc   = '0;
      r.seen  = 1'b0;
      r.stop  = 1'b0;
      r.ovf   = 1'b0;
    end
    r.fidx = s.fidx + 3'd1;
    return r;
  endfunction

  // Configuration writes are taken at any time.
  assign cfg_ready = 1'b1;

  // A character that ends a line needs a free output slot; others never wait.
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && (!q_item.last || out_free);

  // Step the parser by one character, then close the line on its last one.
  always_comb begin
    s1 = st_r;
    if (!st_r.rej && st_r.fidx != FIELD_DONE) begin
      priority if (q_item.is_comma) begin
        s1 = finish_field(st_r, team_r);
      end else if (st_r.fidx == FIELD_VALUE && st_r.fmt == tlp_pkg::FMT_ST) begin
        if (st_r.tpart != TP_DONE) begin
          if (q_item.is_colon) begin
            s1 = finish_time_part(st_r);
          end else begin
            s1 = num_char(st_r, q_item.is_digit, q_item.digit, tlp_pkg::LIM_TIME);
          end
        end
      end else if (st_r.fidx == FIELD_TEAM) begin
        s1 = num_char(st_r, q_item.is_digit, q_item.digit, tlp_pkg::LIM_TEAM);
      end else if (st_r.fidx == FIELD_VALUE && st_r.fmt == tlp_pkg::FMT_SIMP) begin
        s1 = num_char(st_r, q_item.is_digit, q_item.digit, tlp_pkg::LIM_PRESSURE);
      end else begin
        s1 = kw_char(st_r, q_item.code);
      end
    end
    s2 = s1;
    if (!s1.rej && s1.fidx != FIELD_DONE) begin
      if (s1.fidx == FIELD_VALUE) begin
        s2 = finish_field(s1, team_r);
      end else begin
        s2.rej = 1'b1;
      end
    end
    st_nxt = st_r;
    if (q_pop) begin
      st_nxt = q_item.last ? '0 : s1;
    end
  end

  // Verdict fields; anything that does not belong to the command reads zero.
  always_comb begin
    res_accepted = !s2.rej;
    res_kind     = '0;
    res_tel      = 1'b0;
    res_hours    = '0;
    res_minutes  = '0;
    res_seconds  = '0;
    res_sim      = '0;
    res_pressure = '0;
    if (!s2.rej) begin
      res_kind = s2.fmt;
      unique case (s2.fmt)
        tlp_pkg::FMT_CX: begin
          res_tel = kw_is(s2, tlp_pkg::KW_ON, tlp_pkg::KW_ON_LEN);
        end
        tlp_pkg::FMT_ST: begin
          res_hours   = s2.hh;
          res_minutes = s2.mm;
          res_seconds = s2.acc[5:0];
        end
        tlp_pkg::FMT_SIM: begin
          priority if (kw_is(s2, tlp_pkg::KW_ENABLE, tlp_pkg::KW_ENABLE_LEN)) begin
            res_sim = tlp_pkg::SIM_ENABLE;
          end else if (kw_is(s2, tlp_pkg::KW_DISABLE, tlp_pkg::KW_DISABLE_LEN)) begin
            res_sim = tlp_pkg::SIM_DISABLE;
          end else begin
            res_sim = tlp_pkg::SIM_ACTIVATE;
          end
        end
        default: begin
          res_pressure = s2.acc[tlp_pkg::OUT_PRESSURE_BITS-1:0];
        end
      endcase
    end
  end

  // Control state: parser, team number and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      team_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        team_r <= cfg_team_number;
      end
      if (out_free) begin
        out_valid_r <= q_pop && q_item.last;
      end
    end
  end

  // Output register payload loads whenever the last character of a line is taken from the queue.
  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      out_accepted_r <= res_accepted;
      out_kind_r     <= res_kind;
      out_tel_r      <= res_tel;
      out_hours_r    <= res_hours;
      out_minutes_r  <= res_minutes;
      out_seconds_r  <= res_seconds;
      out_sim_r      <= res_sim;
      out_pressure_r <= res_pressure;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_command_kind = out_kind_r;
  assign out_telemetry_on = out_tel_r;
  assign out_hours        = out_hours_r;
  assign out_minutes      = out_minutes_r;
  assign out_seconds      = out_seconds_r;
  assign out_sim_mode     = out_sim_r;
  assign out_pressure     = out_pressure_r;

`ifndef SYNTHESIS
  a_fidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fidx <= FIELD_DONE)
    else $error("field index beyond the last field");
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.last) |=> st_r == '0)
    else $error("parser state not cleared after a line");
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_accepted_r && out_kind_r == tlp_pkg::FMT_ST) |->
    (out_hours_r < 5'd24 && out_minutes_r < 6'd60 && out_seconds_r < 6'd60))
    else $error("accepted time out of range");
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_accepted_r) |->
    (out_kind_r == 2'd0 && !out_tel_r && out_hours_r == 5'd0 &&
     out_minutes_r == 6'd0 && out_seconds_r == 6'd0 && out_sim_r == 2'd0 &&
     out_pressure_r == '0))
    else $error("rejected verdict carries nonzero fields");
`endif

endmodule

// ----- dv/line_verdict_checker.sv -----
`timescale 1ns / 1ps

module line_verdict_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [tlp_pkg::TEAM_BITS-1:0]         cfg_team_number,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [tlp_pkg::CHAR_BITS-1:0]         in_char_code,
  input  logic                                  in_last_char,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic                                  out_accepted,
  input  logic [1:0]                            out_command_kind,
  input  logic                                  out_telemetry_on,
  input  logic [4:0]                            out_hours,
  input  logic [5:0]                            out_minutes,
  input  logic [5:0]                            out_seconds,
  input  logic [1:0]                            out_sim_mode,
  input  logic [tlp_pkg::OUT_PRESSURE_BITS-1:0] out_pressure,
  output int                                    fail_count,
  output int                                    verdicts_pending
);
  import tlp_pkg::*;

  localparam int MAX_PRINTS = 40;

  // Largest value each numeric field may hold before it counts as overflow.
  localparam logic [63:0] TEAM_MAX =
    (TEAM_ID_BITS >= 64) ? '1 : (64'd1 << TEAM_ID_BITS) - 64'd1;
  localparam logic [63:0] TIME_MAX =
    (TIME_NUM_BITS >= 64) ? '1 : (64'd1 << TIME_NUM_BITS) - 64'd1;
  localparam logic [63:0] PRESSURE_MAX =
    (PRESSURE_BITS >= 64) ? '1 : (64'd1 << PRESSURE_BITS) - 64'd1;

  typedef struct packed {
    logic                         accepted;
    logic [1:0]                   kind;
    logic                         tel_on;
    logic [4:0]                   hours;
    logic [5:0]                   minutes;
    logic [5:0]                   seconds;
    logic [1:0]                   sim_mode;
    logic [OUT_PRESSURE_BITS-1:0] pressure;
  } verdict_t;

  verdict_t expected_verdicts[$];

  // Parser state as the block should hold it.
  logic [TEAM_BITS-1:0] team_reg;
  logic [2:0]           fld_idx;
  logic [63:0]          kw_buf;
  logic [3:0]           kw_len;
  logic [63:0]          acc;
  logic                 dig_seen;
  logic                 dig_stop;
  logic                 dig_ovf;
  logic [1:0]           fmt;
  logic                 line_bad;
  logic [1:0]           tpart;
  logic [4:0]           hrs_held;
  logic [5:0]           mins_held;

  initial begin
    fail_count = 0;
    verdicts_pending = 0;
  end

  task automatic report_error(input string msg);
    if (fail_count < MAX_PRINTS) $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  function automatic void clear_field();
    kw_buf   = '0;
    kw_len   = '0;
    acc      = '0;
    dig_seen = 1'b0;
    dig_stop = 1'b0;
    dig_ovf  = 1'b0;
  endfunction

  function automatic void clear_line();
    clear_field();
    fld_idx   = '0;
    fmt       = FMT_CX;
    line_bad  = 1'b0;
    tpart     = '0;
    hrs_held  = '0;
    mins_held = '0;
  endfunction

  // A keyword matches only at its exact length; a saturated length never does.
  function automatic bit kw_match(input logic [63:0] word, input logic [3:0] len);
    return (kw_len == len) && (kw_buf == word);
  endfunction

  function automatic void kw_push(input logic [7:0] c);
    if (kw_len < 4'd8) kw_buf[kw_len*8 +: 8] = c;
    if (kw_len < KW_LEN_SAT) kw_len++;
  endfunction

  // Leading digits build the number; the first non-digit freezes it.
  function automatic void num_push(input logic [7:0] c, input logic [63:0] lim);
    logic [63:0] d;
    if (dig_stop) return;
    if (c < CH_ZERO || c > CH_NINE) begin
      dig_stop = 1'b1;
      return;
    end
    d = 64'(c - CH_ZERO);
    dig_seen = 1'b1;
    if (dig_ovf) return;
    if (acc > (lim - d) / 64'd10) dig_ovf = 1'b1;
    else acc = acc * 64'd10 + d;
  endfunction

  function automatic bit num_good();
    return dig_seen && !dig_ovf;
  endfunction

  // Ends one part of hh:mm:ss; the seconds value stays in the accumulator.
  function automatic void close_time_part();
    if (!num_good()) line_bad = 1'b1;
    else if (tpart == 2'd0) begin
      if (acc >= 64'(HOURS_LIMIT)) line_bad = 1'b1;
      else hrs_held = acc[4:0];
    end else begin
      if (acc >= 64'(MINSEC_LIMIT)) line_bad = 1'b1;
      else if (tpart == 2'd1) mins_held = acc[5:0];
    end
    if (tpart < 2'd2) begin
      acc      = '0;
      dig_seen = 1'b0;
      dig_stop = 1'b0;
      dig_ovf  = 1'b0;
    end
    tpart++;
  endfunction

  function automatic void close_field();
    case (fld_idx)
      3'd0: if (!kw_match(KW_CMD, KW_CMD_LEN)) line_bad = 1'b1;
      3'd1: if (!num_good() || acc != 64'(team_reg)) line_bad = 1'b1;
      3'd2: begin
        if (kw_match(KW_CX, KW_CX_LEN)) fmt = FMT_CX;
        else if (kw_match(KW_ST, KW_ST_LEN)) fmt = FMT_ST;
        else if (kw_match(KW_SIM, KW_SIM_LEN)) fmt = FMT_SIM;
        else if (kw_match(KW_SIMP, KW_SIMP_LEN)) fmt = FMT_SIMP;
        else line_bad = 1'b1;
      end
      default: begin
        case (fmt)
          FMT_CX: begin
            if (!kw_match(KW_ON, KW_ON_LEN) && !kw_match(KW_OFF, KW_OFF_LEN)) line_bad = 1'b1;
          end
          FMT_ST: begin
            if (tpart < 2'd3) close_time_part();
            if (tpart < 2'd3) line_bad = 1'b1;
          end
          FMT_SIM: begin
            if (!kw_match(KW_ENABLE, KW_ENABLE_LEN) && !kw_match(KW_DISABLE, KW_DISABLE_LEN) &&
                !kw_match(KW_ACTIVATE, KW_ACTIVATE_LEN)) line_bad = 1'b1;
          end
          default: if (!num_good()) line_bad = 1'b1;
        endcase
      end
    endcase
    if (fld_idx < 3'd3) clear_field();
    fld_idx++;
  endfunction

  // Advances the parser by one character; returns 1 when a verdict is due.
  function automatic bit predict_char(input logic [7:0] c, input logic last,
                                      output verdict_t v);
    v = '0;
    if (!line_bad && fld_idx < 3'd4) begin
      if (c == CH_COMMA) close_field();
      else if (fld_idx == 3'd3 && fmt == FMT_ST) begin
        if (tpart < 2'd3) begin
          if (c == CH_COLON) close_time_part();
          else num_push(c, TIME_MAX);
        end
      end else if (fld_idx == 3'd1) num_push(c, TEAM_MAX);
      else if (fld_idx == 3'd3 && fmt == FMT_SIMP) num_push(c, PRESSURE_MAX);
      else kw_push(c);
    end
    if (!last) return 1'b0;

    // Line end closes the value field; an earlier end means a missing field.
    if (!line_bad && fld_idx < 3'd4) begin
      if (fld_idx == 3'd3) close_field();
      else line_bad = 1'b1;
    end
    if (!line_bad) begin
      v.accepted = 1'b1;
      v.kind = fmt;
      case (fmt)
        FMT_CX: v.tel_on = kw_match(KW_ON, KW_ON_LEN);
        FMT_ST: begin
          v.hours   = hrs_held;
          v.minutes = mins_held;
          v.seconds = acc[5:0];
        end
        FMT_SIM: begin
          if (kw_match(KW_ENABLE, KW_ENABLE_LEN)) v.sim_mode = SIM_ENABLE;
          else if (kw_match(KW_DISABLE, KW_DISABLE_LEN)) v.sim_mode = SIM_DISABLE;
          else v.sim_mode = SIM_ACTIVATE;
        end
        default: v.pressure = acc[OUT_PRESSURE_BITS-1:0];
      endcase
    end
    clear_line();
    return 1'b1;
  endfunction

  // Watch all three channels; compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    verdict_t pred;
    if (!rst_n) begin
      team_reg = '0;
      clear_line();
      expected_verdicts.delete();
      verdicts_pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_error("verdict transfer with no verdict expected");
        end else begin
          want = expected_verdicts.pop_front();
          check_field("accepted", out_accepted, want.accepted);
          check_field("command_kind", out_command_kind, want.kind);
          check_field("telemetry_on", out_telemetry_on, want.tel_on);
          check_field("hours", out_hours, want.hours);
          check_field("minutes", out_minutes, want.minutes);
          check_field("seconds", out_seconds, want.seconds);
          check_field("sim_mode", out_sim_mode, want.sim_mode);
          check_field("pressure", out_pressure, want.pressure);
        end
      end
      if (cfg_valid && cfg_ready) team_reg = cfg_team_number;
      if (in_valid && !in_stall) begin
        if (predict_char(in_char_code, in_last_char, pred)) expected_verdicts.push_back(pred);
      end
      verdicts_pending <= expected_verdicts.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tlp_pkg::*;

  localparam int NUM_PHASES = 6;
  localparam int CHARS_PER_PHASE = 140;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 5;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [TEAM_BITS-1:0]         cfg_team_number = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [CHAR_BITS-1:0]         in_char_code = '0;
  logic                         in_last_char = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_accepted;
  logic [1:0]                   out_command_kind;
  logic                         out_telemetry_on;
  logic [4:0]                   out_hours;
  logic [5:0]                   out_minutes;
  logic [5:0]                   out_seconds;
  logic [1:0]                   out_sim_mode;
  logic [OUT_PRESSURE_BITS-1:0] out_pressure;

  int fail_count;
  int verdicts_pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  telecommand_line_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_team_number  (cfg_team_number),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_command_kind (out_command_kind),
    .out_telemetry_on (out_telemetry_on),
    .out_hours        (out_hours),
    .out_minutes      (out_minutes),
    .out_seconds      (out_seconds),
    .out_sim_mode     (out_sim_mode),
    .out_pressure     (out_pressure)
  );

  line_verdict_checker verdict_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_team_number  (cfg_team_number),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_command_kind (out_command_kind),
    .out_telemetry_on (out_telemetry_on),
    .out_hours        (out_hours),
    .out_minutes      (out_minutes),
    .out_seconds      (out_seconds),
    .out_sim_mode     (out_sim_mode),
    .out_pressure     (out_pressure),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Random stall on the verdict channel.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // End the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic string pick_junk();
    case ($urandom_range(5))
      0: return " ";
      1: return "x";
      2: return "+";
      3: return ".";
      4: return "-";
      default: return "Z9";
    endcase
  endfunction

  // One part of hh:mm:ss, mostly in range below top.
  function automatic string pick_time_part(input int unsigned top);
    case ($urandom_range(19))
      0: return $sformatf("%0d", $urandom_range(999, 256));
      1: return $sformatf("%0d", $urandom_range(255, top));
      2: return "";
      3: return $sformatf("%0d%s", $urandom_range(top - 1), pick_junk());
      4: return $sformatf("%03d", $urandom_range(top - 1));
      5: return $sformatf("%0d", $urandom_range(top - 1));
      default: return $sformatf("%02d", $urandom_range(top - 1));
    endcase
  endfunction

  function automatic void to_bytes(input string s, ref logic [7:0] q[$]);
    q.delete();
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Mostly well-formed command lines with random content; some noise and damage.
  function automatic void make_line(input logic [TEAM_BITS-1:0] t, ref logic [7:0] q[$]);
    string f_cmd;
    string f_team;
    string f_fmt;
    string f_val;
    string tp_h;
    string tp_m;
    string tp_s;
    int unsigned pv;
    if ($urandom_range(99) < 7) begin
      q.delete();
      repeat ($urandom_range(24, 1)) q.push_back(8'($urandom_range(255)));
      return;
    end

    case ($urandom_range(24))
      0: f_cmd = "cmd";
      1: f_cmd = "CM";
      2: f_cmd = "";
      3: f_cmd = "CMDD";
      default: f_cmd = "CMD";
    endcase

    case ($urandom_range(19))
      0: f_team = $sformatf("00%0d", t);
      1: f_team = $sformatf("%0d%s", t, pick_junk());
      2: f_team = $sformatf("%0d", $urandom_range(65535));
      3: f_team = $sformatf("%0d", 65536 + $urandom_range(2000000));
      4: f_team = "";
      5: f_team = $sformatf("-%0d", t);
      6: f_team = "123456789012";
      default: f_team = $sformatf("%0d", t);
    endcase

    case (2'($urandom_range(3)))
      FMT_CX: begin
        f_fmt = "CX";
        case ($urandom_range(11))
          0: f_val = "on";
          1: f_val = "ONN";
          2: f_val = "OF";
          3: f_val = "";
          default: f_val = $urandom_range(1) ? "ON" : "OFF";
        endcase
      end
      FMT_ST: begin
        f_fmt = "ST";
        tp_h = pick_time_part(24);
        tp_m = pick_time_part(60);
        tp_s = pick_time_part(60);
        case ($urandom_range(9))
          0: f_val = {tp_h, ":", tp_m};
          1: f_val = {tp_h, ":", tp_m, ":", tp_s, ":", pick_time_part(60)};
          default: f_val = {tp_h, ":", tp_m, ":", tp_s};
        endcase
      end
      FMT_SIM: begin
        f_fmt = "SIM";
        case ($urandom_range(11))
          0: f_val = "ENABLED";
          1: f_val = "activate";
          2: f_val = "DISABLE ";
          3: f_val = "";
          4, 5, 6: f_val = "ENABLE";
          7, 8: f_val = "DISABLE";
          default: f_val = "ACTIVATE";
        endcase
      end
      default: begin
        f_fmt = "SIMP";
        pv = $urandom();
        case ($urandom_range(11))
          0: f_val = "0";
          1: f_val = "4294967295";
          2: f_val = $sformatf("%0d", 64'd4294967296 + 64'($urandom_range(1000)));
          3: f_val = "";
          4: f_val = $sformatf("-%0d", pv);
          5: f_val = $sformatf("%0d%s", $urandom_range(99999), pick_junk());
          6: f_val = $sformatf("%0d", $urandom_range(999));
          default: f_val = $sformatf("%0d", pv);
        endcase
      end
    endcase

    // An unknown format keyword, sometimes longer than the keyword buffer.
    if ($urandom_range(14) == 0) begin
      case ($urandom_range(4))
        0: f_fmt = "cx";
        1: f_fmt = "SIMPS";
        2: f_fmt = "STATUSWORDS";
        3: f_fmt = "S";
        default: f_fmt = "";
      endcase
    end

    if ($urandom_range(9) == 0) f_val = {f_val, ",", pick_junk(), ",7"};
    to_bytes({f_cmd, ",", f_team, ",", f_fmt, ",", f_val}, q);

    // Cut the line short, or damage one character.
    if ($urandom_range(9) == 0) q = q[0:$urandom_range(q.size() - 1)];
    if ($urandom_range(11) == 0) q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
  endfunction

  // One character transfer, preceded by a random gap.
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_line(input logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) send_char(q[i], i == q.size() - 1);
    in_valid <= 1'b0;
  endtask

  // Wait until every predicted verdict has been transferred.
  task automatic drain();
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
  endtask

  task automatic write_team(input logic [TEAM_BITS-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_team_number <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] line_q[$];
    logic [TEAM_BITS-1:0] team;
    string directed[$];
    int sent;

    // Directed lines, run with the team number at its maximum.
    directed = '{
      "CMD,65535,CX,ON", "CMD,65535,CX,OFF", "CMD,65535,ST,23:59:59",
      "CMD,65535,ST,24:00:00", "CMD,65535,ST,00:00:60", "CMD,65535,ST,12:60:00",
      "CMD,65535,ST,1a:2b:3c,extra", "CMD,65535,ST,12:30", "CMD,65535,ST,256:00:00",
      "CMD,65535,ST,1:2:3:4", "CMD,65535,SIM,ENABLE", "CMD,65535,SIM,DISABLE",
      "CMD,65535,SIM,ACTIVATE", "CMD,65535,SIMP,4294967295", "CMD,65535,SIMP,4294967296",
      "CMD,65535,SIMP,0", "CMD,65535,SIMP,-5", "CMD,65536,CX,ON", "CMD,065535x,CX,ON",
      "CMD,,CX,ON", "CMD,65535,CX", "CMD,65535,ACTIVATES,ON", "C",
      "CMD,65535,CX,ON,junk,more"
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: team = '1;
        1: team = '0;
        2: team = TEAM_BITS'(1);
        3: team = TEAM_BITS'($urandom_range(65535));
        4: team = TEAM_BITS'($urandom_range(999));
        default: team = '1;
      endcase
      write_team(team);

      // Idle pattern cycles through none, sender gaps, receiver stalls, both.
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase

      if (p == 0) begin
        foreach (directed[i]) begin
          to_bytes(directed[i], line_q);
          send_line(line_q);
        end
      end

      sent = 0;
      while (sent < CHARS_PER_PHASE) begin
        make_line(team, line_q);
        send_line(line_q);
        sent += line_q.size();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tlp_pkg.sv
hw/rtl/tlp_front.sv
hw/rtl/tlp_back.sv
hw/rtl/telecommand_line_parser.sv
dv/line_verdict_checker.sv
dv/tb_top.sv
